// File: design/pfg_pkg.sv
// Shared types and constants for the playfield pixel generator.
`default_nettype none
package pfg_pkg;

    // Item operation codes
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_PF0      = 3'd1,
        OP_PF1      = 3'd2,
        OP_PF2      = 3'd3,
        OP_CTRL     = 3'd4,
        OP_PF_COLOR = 3'd5,
        OP_P0_COLOR = 3'd6,
        OP_P1_COLOR = 3'd7
    } t_opcode;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_COLL_MASK_OFF = 3'd0,
        CFG_COLL_ENABLED  = 3'd1,
        CFG_PF_ENABLED    = 3'd2,
        CFG_DEBUG_ON      = 3'd3,
        CFG_DEBUG_COLOR   = 3'd4
    } t_cfg_index;

    localparam int unsigned PATTERN_W   = 20;

    localparam logic [PATTERN_W-1:0] KEEP_PF0 = 20'hFFFF0;
    localparam logic [PATTERN_W-1:0] KEEP_PF1 = 20'hFF00F;
    localparam logic [PATTERN_W-1:0] KEEP_PF2 = 20'h00FFF;

    localparam logic [15:0] MASK_ALL_ON  = 16'hFFFF;
    localparam logic [15:0] MASK_PF_BIT  = 16'h8000;

    localparam logic [7:0] X_LEFT_START  = 8'd0;
    localparam logic [7:0] X_RIGHT_START = 8'd80;
    localparam logic [7:0] X_LINE_END    = 8'd160;
    localparam logic [5:0] MIRROR_BASE   = 6'd39;
    localparam logic [5:0] HALF_CELLS    = 6'd20;

    localparam logic [2:0] CTRL_SCORE_FIELD = 3'h6;
    localparam logic [2:0] CTRL_SCORE_CODE  = 3'h2;

    // Configuration register contents
    typedef struct packed {
        logic [15:0] coll_mask_off;
        logic        coll_enabled;
        logic        pf_enabled;
        logic        debug_on;
        logic [7:0]  debug_color;
    } t_cfg;

    // Video register state handed to the sampler and output stage
    typedef struct packed {
        logic [PATTERN_W-1:0] line_pattern;
        logic                 reflect_ctrl;
        logic [7:0]           color_left;
        logic [7:0]           color_right;
    } t_vid_status;

endpackage
`default_nettype wire

// File: design/pfg_if.sv
// Handshake channel interfaces for items, results and configuration writes.
`default_nettype none
interface pfg_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] data_value;
    logic [7:0] beam_x;

    modport source (output valid, opcode, data_value, beam_x, input ready);
    modport sink   (input valid, opcode, data_value, beam_x, output ready);
endinterface

interface pfg_result_if;
    logic        valid;
    logic        ready;
    logic        pixel_on;
    logic [15:0] collision_mask;
    logic [7:0]  color_left;
    logic [7:0]  color_right;

    modport source (output valid, pixel_on, collision_mask, color_left, color_right,
                    input ready);
    modport sink   (input valid, pixel_on, collision_mask, color_left, color_right,
                    output ready);
endinterface

interface pfg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/pfg_cfg_regs.sv
// Configuration register file written through the configuration channel.
`default_nettype none
module pfg_cfg_regs (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_wr_en,
    input  wire [2:0]               i_wr_index,
    input  wire [15:0]              i_wr_data,
    output pfg_pkg::t_cfg           o_cfg
);
    pfg_pkg::t_cfg r_cfg;
    pfg_pkg::t_cfg n_cfg;

    // Decode the write; indexes past the list are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (pfg_pkg::t_cfg_index'(i_wr_index))
                pfg_pkg::CFG_COLL_MASK_OFF: n_cfg.coll_mask_off = i_wr_data;
                pfg_pkg::CFG_COLL_ENABLED:  n_cfg.coll_enabled  = i_wr_data[0];
                pfg_pkg::CFG_PF_ENABLED:    n_cfg.pf_enabled    = i_wr_data[0];
                pfg_pkg::CFG_DEBUG_ON:      n_cfg.debug_on      = i_wr_data[0];
                pfg_pkg::CFG_DEBUG_COLOR:   n_cfg.debug_color   = i_wr_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coll_mask_off <= '0;
            r_cfg.coll_enabled  <= 1'b1;
            r_cfg.pf_enabled    <= 1'b1;
            r_cfg.debug_on      <= 1'b0;
            r_cfg.debug_color   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// File: design/pfg_video_regs.sv
// Playfield pattern, control and color registers updated by write items.
`default_nettype none
module pfg_video_regs (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_accept,
    input  wire [2:0]               i_opcode,
    input  wire [7:0]               i_data_value,
    input  pfg_pkg::t_cfg           i_cfg,
    output pfg_pkg::t_vid_status    o_status
);
    logic [pfg_pkg::PATTERN_W-1:0] r_line_pattern, n_line_pattern;
    logic       r_reflect_ctrl, n_reflect_ctrl;
    logic       r_score_mode,   n_score_mode;
    logic [7:0] r_object_color, n_object_color;
    logic [7:0] r_p0_color,     n_p0_color;
    logic [7:0] r_p1_color,     n_p1_color;
    logic [7:0] data_rev;

    assign data_rev = {<<{i_data_value}};

    // Register write decode
    always_comb begin
        n_line_pattern = r_line_pattern;
        n_reflect_ctrl = r_reflect_ctrl;
        n_score_mode   = r_score_mode;
        n_object_color = r_object_color;
        n_p0_color     = r_p0_color;
        n_p1_color     = r_p1_color;
        if (i_accept) begin
            case (pfg_pkg::t_opcode'(i_opcode))
                pfg_pkg::OP_TICK: ;
                pfg_pkg::OP_PF0:
                    n_line_pattern = (r_line_pattern & pfg_pkg::KEEP_PF0)
                                   | {16'd0, i_data_value[7:4]};
                pfg_pkg::OP_PF1:
                    n_line_pattern = (r_line_pattern & pfg_pkg::KEEP_PF1)
                                   | {8'd0, data_rev, 4'd0};
                pfg_pkg::OP_PF2:
                    n_line_pattern = (r_line_pattern & pfg_pkg::KEEP_PF2)
                                   | {i_data_value, 12'd0};
                pfg_pkg::OP_CTRL: begin
                    n_reflect_ctrl = i_data_value[0];
                    n_score_mode   = ((i_data_value[2:0] & pfg_pkg::CTRL_SCORE_FIELD)
                                      == pfg_pkg::CTRL_SCORE_CODE);
                end
                pfg_pkg::OP_PF_COLOR: n_object_color = i_data_value;
                pfg_pkg::OP_P0_COLOR: n_p0_color     = i_data_value;
                default:              n_p1_color     = i_data_value;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pattern <= '0;
            r_reflect_ctrl <= 1'b0;
            r_score_mode   <= 1'b0;
            r_object_color <= '0;
            r_p0_color     <= '0;
            r_p1_color     <= '0;
        end else begin
            r_line_pattern <= n_line_pattern;
            r_reflect_ctrl <= n_reflect_ctrl;
            r_score_mode   <= n_score_mode;
            r_object_color <= n_object_color;
            r_p0_color     <= n_p0_color;
            r_p1_color     <= n_p1_color;
        end
    end

    // Pattern and reflect are unchanged by a tick; colors follow the write at once
    always_comb begin
        o_status.line_pattern = r_line_pattern;
        o_status.reflect_ctrl = r_reflect_ctrl;
        if (i_cfg.debug_on) begin
            o_status.color_left  = i_cfg.debug_color;
            o_status.color_right = i_cfg.debug_color;
        end else if (n_score_mode) begin
            o_status.color_left  = n_p0_color;
            o_status.color_right = n_p1_color;
        end else begin
            o_status.color_left  = n_object_color;
            o_status.color_right = n_object_color;
        end
    end
endmodule
`default_nettype wire

// File: design/pfg_sampler.sv
// Beam sampler: reflect latch, pattern bit select and held pixel/collision mask.
`default_nettype none
module pfg_sampler (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_tick,
    input  wire [7:0]               i_beam_x,
    input  pfg_pkg::t_cfg           i_cfg,
    input  pfg_pkg::t_vid_status    i_status,
    output logic                    o_pixel_on,
    output logic [15:0]             o_collision_mask
);
    logic        r_reflect_latched, n_reflect_latched;
    logic        r_held_pixel,      n_held_pixel;
    logic [15:0] r_held_coll,       n_held_coll;
    logic        latch_pos;
    logic        sample_pos;
    logic [5:0]  col_idx;
    logic [5:0]  bit_sel;
    logic        pix;

    assign latch_pos  = (i_beam_x == pfg_pkg::X_LEFT_START)
                     || (i_beam_x == pfg_pkg::X_RIGHT_START);
    assign sample_pos = (i_beam_x[1:0] == 2'b00);
    assign col_idx    = i_beam_x[7:2];

    // Reflect latch is taken before the sample at the same position
    assign n_reflect_latched = (i_tick && latch_pos) ? i_status.reflect_ctrl
                                                      : r_reflect_latched;

    // Pattern bit for this position: left as stored, right repeated or mirrored
    always_comb begin
        if (i_beam_x < pfg_pkg::X_RIGHT_START) begin
            bit_sel = col_idx;
        end else if (n_reflect_latched) begin
            bit_sel = pfg_pkg::MIRROR_BASE - col_idx;
        end else begin
            bit_sel = col_idx - pfg_pkg::HALF_CELLS;
        end
        pix = 1'b0;
        if (i_beam_x < pfg_pkg::X_LINE_END && i_cfg.pf_enabled
            && bit_sel < 6'(pfg_pkg::PATTERN_W)) begin
            pix = i_status.line_pattern[bit_sel[4:0]];
        end
    end

    // Held pixel and mask change only on a sampled tick
    always_comb begin
        n_held_pixel = r_held_pixel;
        n_held_coll  = r_held_coll;
        if (i_tick && sample_pos) begin
            n_held_pixel = pix;
            if (!pix) begin
                n_held_coll = i_cfg.coll_mask_off;
            end else if (i_cfg.coll_enabled) begin
                n_held_coll = pfg_pkg::MASK_ALL_ON;
            end else begin
                n_held_coll = pfg_pkg::MASK_PF_BIT | i_cfg.coll_mask_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reflect_latched <= 1'b0;
            r_held_pixel      <= 1'b0;
            r_held_coll       <= '0;
        end else begin
            r_reflect_latched <= n_reflect_latched;
            r_held_pixel      <= n_held_pixel;
            r_held_coll       <= n_held_coll;
        end
    end

    assign o_pixel_on       = n_held_pixel;
    assign o_collision_mask = n_held_coll;
endmodule
`default_nettype wire

// File: design/playfield_pixel_generator_top.sv
// Top level of the playfield pixel generator: channels, state and result register.
// The output register captures the result of each item as the item is accepted.
// Throughput: one item per cycle while input ready is high; ready holds while the result register is
// empty or being drained, so a result left waiting and not taken stops the next transaction.
// Configuration writes are registered in the configuration register file; the config channel is always ready.
// Reset (synchronous, active low) clears the configuration, video and sampler state and the result register valid;
// collisions_enabled and playfield_enabled come out of reset as 1.
`default_nettype none
module playfield_pixel_generator_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pfg_item_if.sink    i_item,
    pfg_cfg_if.sink     i_cfg,
    pfg_result_if.source o_result
);
    pfg_pkg::t_cfg        cfg;
    pfg_pkg::t_vid_status status;
    logic                 item_accept;
    logic                 tick;
    logic                 n_pixel_on;
    logic [15:0]          n_collision_mask;

    logic                 r_out_valid;
    logic                 r_pixel_on;
    logic [15:0]          r_collision_mask;
    logic [7:0]           r_color_left;
    logic [7:0]           r_color_right;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign item_accept  = i_item.valid && i_item.ready;
    assign tick         = item_accept
                       && (pfg_pkg::t_opcode'(i_item.opcode) == pfg_pkg::OP_TICK);

    pfg_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    pfg_video_regs u_video_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (item_accept),
        .i_opcode     (i_item.opcode),
        .i_data_value (i_item.data_value),
        .i_cfg        (cfg),
        .o_status     (status)
    );

    pfg_sampler u_sampler (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tick           (tick),
        .i_beam_x         (i_item.beam_x),
        .i_cfg            (cfg),
        .i_status         (status),
        .o_pixel_on       (n_pixel_on),
        .o_collision_mask (n_collision_mask)
    );

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (item_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (item_accept) begin
            r_pixel_on       <= n_pixel_on;
            r_collision_mask <= n_collision_mask;
            r_color_left     <= status.color_left;
            r_color_right    <= status.color_right;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.pixel_on       = r_pixel_on;
    assign o_result.collision_mask = r_collision_mask;
    assign o_result.color_left     = r_color_left;
    assign o_result.color_right    = r_color_right;
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the playfield pixel generator: directed rows, then random scanlines.
`default_nettype none
module tb_top;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int DIR_ROWS        = 25;

    // One result transaction as seen on the output channel
    typedef struct packed {
        logic        pixel_on;
        logic [15:0] collision_mask;
        logic [7:0]  color_left;
        logic [7:0]  color_right;
    } t_beam_result;

    // Directed row: item fields, plus a typed-in result where it is obvious
    typedef struct packed {
        pfg_pkg::t_opcode op;
        logic [7:0]       data_value;
        logic [7:0]       beam_x;
        logic             literal;
        t_beam_result     want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pfg_item_if   item_ch ();
    pfg_cfg_if    cfg_ch ();
    pfg_result_if res_ch ();

    playfield_pixel_generator_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    always #4 i_clk = ~i_clk;

    // Shadow of the block's registers and video state
    pfg_pkg::t_cfg                 shadow_cfg;
    logic [pfg_pkg::PATTERN_W-1:0] line_bits;
    logic                          reflect_req;
    logic                          reflect_held;
    logic                          score_on;
    logic [7:0]                    pf_color;
    logic [7:0]                    p0_color;
    logic [7:0]                    p1_color;
    logic                          held_on;
    logic [15:0]                   held_mask;

    t_beam_result pending_pixels [$];
    int           mismatches = 0;
    int           cycles = 0;
    bit           tx_idle_on;
    bit           rx_idle_on;
    bit           hold_off_pending;

    // Directed rows: reset values, every opcode, line edges, reflect latch, beyond-line samples
    t_stim_row dir_rows [DIR_ROWS] = '{
        '{pfg_pkg::OP_TICK,     8'h00, 8'd1,   1'b1, '{1'b0, 16'h0000, 8'h00, 8'h00}},
        '{pfg_pkg::OP_TICK,     8'hFF, 8'd0,   1'b1, '{1'b0, 16'h0000, 8'h00, 8'h00}},
        '{pfg_pkg::OP_PF0,      8'hFF, 8'hFF,  1'b1, '{1'b0, 16'h0000, 8'h00, 8'h00}},
        '{pfg_pkg::OP_PF1,      8'h01, 8'd0,   1'b0, '0},
        '{pfg_pkg::OP_PF2,      8'h80, 8'd0,   1'b0, '0},
        '{pfg_pkg::OP_PF_COLOR, 8'hFF, 8'd0,   1'b1, '{1'b0, 16'h0000, 8'hFF, 8'hFF}},
        '{pfg_pkg::OP_TICK,     8'h00, 8'd0,   1'b1, '{1'b1, 16'hFFFF, 8'hFF, 8'hFF}},
        '{pfg_pkg::OP_TICK,     8'h00, 8'd44,  1'b0, '0},
        '{pfg_pkg::OP_TICK,     8'h00, 8'd76,  1'b0, '0},
        '{pfg_pkg::OP_CTRL,     8'h01, 8'd0,   1'b0, '0},
        '{pfg_pkg::OP_TICK,     8'h00, 8'd80,  1'b0, '0},
        '{pfg_pkg::OP_TICK,     8'h00, 8'd159, 1'b0, '0},
        '{pfg_pkg::OP_TICK,     8'h00, 8'd156, 1'b0, '0},
        '{pfg_pkg::OP_TICK,     8'h00, 8'd160, 1'b1, '{1'b0, 16'h0000, 8'hFF, 8'hFF}},
        '{pfg_pkg::OP_TICK,     8'h00, 8'd255, 1'b0, '0},
        '{pfg_pkg::OP_TICK,     8'h00, 8'd252, 1'b0, '0},
        '{pfg_pkg::OP_CTRL,     8'h02, 8'd0,   1'b0, '0},
        '{pfg_pkg::OP_P0_COLOR, 8'h00, 8'd0,   1'b0, '0},
        '{pfg_pkg::OP_P1_COLOR, 8'hA5, 8'd0,   1'b0, '0},
        '{pfg_pkg::OP_TICK,     8'h00, 8'd80,  1'b0, '0},
        '{pfg_pkg::OP_TICK,     8'h00, 8'd0,   1'b0, '0},
        '{pfg_pkg::OP_CTRL,     8'hFE, 8'd0,   1'b0, '0},
        '{pfg_pkg::OP_PF1,      8'h00, 8'd0,   1'b0, '0},
        '{pfg_pkg::OP_PF0,      8'h0F, 8'd0,   1'b0, '0},
        '{pfg_pkg::OP_TICK,     8'h00, 8'd4,   1'b0, '0}
    };

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Apply one item to the shadow state and return the result it produces
    function automatic t_beam_result step_playfield(pfg_pkg::t_opcode op, logic [7:0] d,
                                                    logic [7:0] pos);
        logic [pfg_pkg::PATTERN_W-1:0] shown;
        logic [7:0]                    flipped;
        int                            col;
        int                            idx;
        logic                          on;
        t_beam_result                  r;
        case (op)
            pfg_pkg::OP_TICK: begin
                // reflect is latched before the sample at the same position
                if (pos == pfg_pkg::X_LEFT_START || pos == pfg_pkg::X_RIGHT_START)
                    reflect_held = reflect_req;
                if (pos[1:0] == 2'b00) begin
                    shown = shadow_cfg.pf_enabled ? line_bits : '0;
                    col   = int'(pos[7:2]);
                    on    = 1'b0;
                    if (pos < pfg_pkg::X_LINE_END) begin
                        if (pos < pfg_pkg::X_RIGHT_START)
                            idx = col;
                        else if (reflect_held)
                            idx = int'(pfg_pkg::MIRROR_BASE) - col;
                        else
                            idx = col - int'(pfg_pkg::HALF_CELLS);
                        on = shown[idx];
                    end
                    held_on = on;
                    if (!on)
                        held_mask = shadow_cfg.coll_mask_off;
                    else if (shadow_cfg.coll_enabled)
                        held_mask = pfg_pkg::MASK_ALL_ON;
                    else
                        held_mask = pfg_pkg::MASK_PF_BIT | shadow_cfg.coll_mask_off;
                end
            end
            pfg_pkg::OP_PF0:
                line_bits = (line_bits & pfg_pkg::KEEP_PF0) | {16'b0, d[7:4]};
            pfg_pkg::OP_PF1: begin
                for (int i = 0; i < 8; i++)
                    flipped[7-i] = d[i];
                line_bits = (line_bits & pfg_pkg::KEEP_PF1) | {8'b0, flipped, 4'b0};
            end
            pfg_pkg::OP_PF2:
                line_bits = (line_bits & pfg_pkg::KEEP_PF2) | {d, 12'b0};
            pfg_pkg::OP_CTRL: begin
                reflect_req = d[0];
                score_on    = ((d[2:0] & pfg_pkg::CTRL_SCORE_FIELD)
                               == pfg_pkg::CTRL_SCORE_CODE);
            end
            pfg_pkg::OP_PF_COLOR: pf_color = d;
            pfg_pkg::OP_P0_COLOR: p0_color = d;
            default: p1_color = d;
        endcase
        r.pixel_on       = held_on;
        r.collision_mask = held_mask;
        if (shadow_cfg.debug_on) begin
            r.color_left  = shadow_cfg.debug_color;
            r.color_right = shadow_cfg.debug_color;
        end else if (score_on) begin
            r.color_left  = p0_color;
            r.color_right = p1_color;
        end else begin
            r.color_left  = pf_color;
            r.color_right = pf_color;
        end
        return r;
    endfunction

    // Register settings per phase; fixed extremes on some, random on the rest
    function automatic pfg_pkg::t_cfg phase_setting(int p);
        pfg_pkg::t_cfg c;
        c.coll_mask_off = 16'($urandom_range(0, 65535));
        c.coll_enabled  = 1'($urandom_range(0, 1));
        c.pf_enabled    = ($urandom_range(0, 3) != 0);
        c.debug_on      = 1'($urandom_range(0, 1));
        c.debug_color   = 8'($urandom_range(0, 255));
        case (p)
            0: c = '{16'hFFFF, 1'b0, 1'b1, 1'b0, 8'h00};
            1: c = '{16'h0000, 1'b1, 1'b1, 1'b1, 8'hFF};
            3: begin
                c.coll_enabled = 1'b0;
                c.pf_enabled   = 1'b0;
                c.debug_on     = 1'b0;
            end
            5: c = '{16'hFFFF, 1'b1, 1'b1, 1'b1, 8'h00};
            default: ;
        endcase
        return c;
    endfunction

    // Offer one item, wait for the transaction, record what it should produce
    task automatic send_item(pfg_pkg::t_opcode op, logic [7:0] d, logic [7:0] pos,
                             logic literal, t_beam_result want);
        t_beam_result predicted;
        int           gap;
        item_ch.valid      <= 1'b1;
        item_ch.opcode     <= op;
        item_ch.data_value <= d;
        item_ch.beam_x     <= pos;
        do @(posedge i_clk); while (!item_ch.ready);
        predicted = step_playfield(op, d, pos);
        pending_pixels.push_back(literal ? want : predicted);
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // One register write; valid stays high for a following write
    task automatic write_reg(pfg_pkg::t_cfg_index index, logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (index)
            pfg_pkg::CFG_COLL_MASK_OFF: shadow_cfg.coll_mask_off = value;
            pfg_pkg::CFG_COLL_ENABLED:  shadow_cfg.coll_enabled  = value[0];
            pfg_pkg::CFG_PF_ENABLED:    shadow_cfg.pf_enabled    = value[0];
            pfg_pkg::CFG_DEBUG_ON:      shadow_cfg.debug_on      = value[0];
            pfg_pkg::CFG_DEBUG_COLOR:   shadow_cfg.debug_color   = value[7:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(pfg_pkg::t_cfg c);
        write_reg(pfg_pkg::CFG_COLL_MASK_OFF, c.coll_mask_off);
        write_reg(pfg_pkg::CFG_COLL_ENABLED, {15'b0, c.coll_enabled});
        write_reg(pfg_pkg::CFG_PF_ENABLED, {15'b0, c.pf_enabled});
        write_reg(pfg_pkg::CFG_DEBUG_ON, {15'b0, c.debug_on});
        write_reg(pfg_pkg::CFG_DEBUG_COLOR, {8'b0, c.debug_color});
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering items until every expected result has come out
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Beam sweeps with random register writes and some stray positions mixed in
    task automatic run_scanlines(int count);
        int beam;
        int r;
        beam = 0;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                beam = (beam + (($urandom_range(0, 2) == 0) ? 1 : 4)) % 160;
                send_item(pfg_pkg::OP_TICK, 8'($urandom_range(0, 255)), 8'(beam),
                          1'b0, '0);
            end else if (r < 75) begin
                send_item(pfg_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'b0, '0);
            end else begin
                send_item(pfg_pkg::t_opcode'($urandom_range(1, 7)),
                          8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end
    endtask

    // Result side ready: random stalls, one long hold-off on request
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else if (rx_idle_on) begin
                stall = pick_gap();
                res_ch.ready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_beam_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("result transaction with no expectation pending");
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (res_ch.pixel_on !== want.pixel_on) begin
                    $error("pixel_on: expected %0h, got %0h", want.pixel_on, res_ch.pixel_on);
                    mismatches++;
                end
                if (res_ch.collision_mask !== want.collision_mask) begin
                    $error("collision_mask: expected %h, got %h",
                           want.collision_mask, res_ch.collision_mask);
                    mismatches++;
                end
                if (res_ch.color_left !== want.color_left) begin
                    $error("color_left: expected %h, got %h",
                           want.color_left, res_ch.color_left);
                    mismatches++;
                end
                if (res_ch.color_right !== want.color_right) begin
                    $error("color_right: expected %h, got %h",
                           want.color_right, res_ch.color_right);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Main sequence
    initial begin
        pfg_pkg::t_cfg setting;
        i_rst_n            = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.opcode     = pfg_pkg::OP_TICK;
        item_ch.data_value = 8'h00;
        item_ch.beam_x     = 8'h00;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = pfg_pkg::CFG_COLL_MASK_OFF;
        cfg_ch.data        = 16'h0000;
        tx_idle_on         = 1'b1;
        rx_idle_on         = 1'b1;
        hold_off_pending   = 1'b0;
        shadow_cfg         = '{16'h0000, 1'b1, 1'b1, 1'b0, 8'h00};
        line_bits          = '0;
        reflect_req        = 1'b0;
        reflect_held       = 1'b0;
        score_on           = 1'b0;
        pf_color           = 8'h00;
        p0_color           = 8'h00;
        p1_color           = 8'h00;
        held_on            = 1'b0;
        held_mask          = 16'h0000;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].data_value, dir_rows[i].beam_x,
                      dir_rows[i].literal, dir_rows[i].want);

        // phase 1 runs with no idling; phase 2 holds the result side off
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            setting = phase_setting(p);
            load_settings(setting);
            tx_idle_on = (p != 1) && (p != 2);
            rx_idle_on = (p != 1);
            if (p == 2)
                hold_off_pending = 1'b1;
            run_scanlines(ITEMS_PER_PHASE);
        end
        drain_results();

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
design/pfg_pkg.sv
design/pfg_if.sv
design/pfg_cfg_regs.sv
design/pfg_video_regs.sv
design/pfg_sampler.sv
design/playfield_pixel_generator_top.sv
bench/tb_top.sv
